@@ rtl/tuc_pkg.sv @@
// tuc_pkg: shared widths, character codes, radix constants and the
// character class word of the text-to-unsigned converter.
// No dependencies; used by tuc_classify and text_to_unsigned_converter.
package tuc_pkg;

  localparam int VALUE_BITS  = 32;
  localparam int OFFSET_BITS = 16;
  localparam int CHAR_BITS   = 8;
  localparam int BASE_BITS   = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_UA    = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UX    = 8'h58;
  localparam logic [CHAR_BITS-1:0] CHAR_UZ    = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_LA    = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LX    = 8'h78;
  localparam logic [CHAR_BITS-1:0] CHAR_LZ    = 8'h7A;

  localparam logic [BASE_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_MIN  = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_MAX  = 6'd36;

  // Class of one character word.
  typedef struct packed {
    logic                 nul;
    logic                 blank;
    logic                 sign;
    logic                 minus;
    logic                 zero;
    logic                 is_x;
    logic                 is_digit;
    logic [BASE_BITS-1:0] digit;
  } tuc_class_t;

endpackage

@@ rtl/tuc_classify.sv @@
// tuc_classify: decodes one character into NUL, blank, sign, prefix and
// digit flags plus the digit value 0..35. Depends on tuc_pkg.
module tuc_classify (
  input  logic [tuc_pkg::CHAR_BITS-1:0] char_code,
  output tuc_pkg::tuc_class_t           cls
);

  always_comb begin
    cls          = '0;
    cls.nul      = (char_code == tuc_pkg::CHAR_NUL);
    cls.blank    = (char_code == tuc_pkg::CHAR_SPACE) || (char_code == tuc_pkg::CHAR_TAB);
    cls.minus    = (char_code == tuc_pkg::CHAR_MINUS);
    cls.sign     = cls.minus || (char_code == tuc_pkg::CHAR_PLUS);
    cls.zero     = (char_code == tuc_pkg::CHAR_ZERO);
    cls.is_x     = (char_code == tuc_pkg::CHAR_UX) || (char_code == tuc_pkg::CHAR_LX);
    if (char_code >= tuc_pkg::CHAR_ZERO && char_code <= tuc_pkg::CHAR_NINE) begin
      cls.is_digit = 1'b1;
      cls.digit    = tuc_pkg::BASE_BITS'(char_code - tuc_pkg::CHAR_ZERO);
    end else if (char_code >= tuc_pkg::CHAR_UA && char_code <= tuc_pkg::CHAR_UZ) begin
      cls.is_digit = 1'b1;
      cls.digit    = tuc_pkg::BASE_BITS'(char_code - tuc_pkg::CHAR_UA) + tuc_pkg::BASE_DEC;
    end else if (char_code >= tuc_pkg::CHAR_LA && char_code <= tuc_pkg::CHAR_LZ) begin
      cls.is_digit = 1'b1;
      cls.digit    = tuc_pkg::BASE_BITS'(char_code - tuc_pkg::CHAR_LA) + tuc_pkg::BASE_DEC;
    end
  end

endmodule

@@ rtl/text_to_unsigned_converter.sv @@
// text_to_unsigned_converter: streaming string-to-unsigned parser, top level.
// Depends on tuc_pkg and tuc_classify.
//
// One character word enters per cycle on the in_valid/in_stall channel while
// in_stall is low; a word with start_req set begins a new string and latches
// base_request (0 auto-detects, 2..36 is used, anything else means 10). The
// parser skips spaces and tabs, takes one optional sign, handles a
// 0 / 0x / 0X prefix, and accumulates digits as value*base+digit modulo 2^32.
// The first NUL, non-digit or out-of-range digit ends the string and produces
// exactly one result word (value, negated if a minus was seen, and
// end_offset, the saturating count of consumed characters); later characters
// are dropped until the next start. A start in mid-string drops the old parse
// without a result. Each character is held in the input register while the
// parse step works on it, and the parse step writes the result register, so
// a stop character passes the input register and then the result register
// before its result shows; throughput is one character per cycle while no
// stall holds the flow, bounded by the 32x6 multiply-add on the accumulator
// in the parse step. While a result waits under out_stall, the input register
// can still take one character, and in_stall rises once it holds one.
module text_to_unsigned_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tuc_pkg::CHAR_BITS-1:0]   char_code,
  input  logic [tuc_pkg::BASE_BITS-1:0]   base_request,
  input  logic                            start_req,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tuc_pkg::VALUE_BITS-1:0]  value,
  output logic [tuc_pkg::OFFSET_BITS-1:0] end_offset
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEAD, PH_PREFIX, PH_X16, PH_XAUTO, PH_DIGITS, PH_DONE
  } phase_t;

  // Input register.
  logic                           in_full;
  logic [tuc_pkg::CHAR_BITS-1:0]  char_q;
  logic [tuc_pkg::BASE_BITS-1:0]  base_q;
  logic                           start_q;

  // Parser state.
  phase_t                          phase, phase_next;
  logic [tuc_pkg::VALUE_BITS-1:0]  accumulator, accumulator_next;
  logic                            negative, negative_next;
  logic [tuc_pkg::BASE_BITS-1:0]   active_base, active_base_next;
  logic [tuc_pkg::OFFSET_BITS-1:0] consumed_count, consumed_count_next;

  tuc_pkg::tuc_class_t cls;

  logic                            advance;
  logic                            emit;
  logic                            count_inc;
  logic                            do_prefix;
  logic                            do_digit;
  logic [tuc_pkg::OFFSET_BITS-1:0] cnt_work;
  logic [tuc_pkg::VALUE_BITS-1:0]  value_next;
  logic [tuc_pkg::OFFSET_BITS-1:0] end_offset_next;

  tuc_classify u_classify (
    .char_code (char_q),
    .cls       (cls)
  );

  // The parse step runs whenever the result register is free or being taken.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_full && !advance;

  always_comb begin
    phase_next       = phase;
    accumulator_next = accumulator;
    negative_next    = negative;
    active_base_next = active_base;
    cnt_work         = consumed_count;
    count_inc        = 1'b0;
    do_prefix        = 1'b0;
    do_digit         = 1'b0;
    emit             = 1'b0;
    value_next       = '0;
    end_offset_next  = '0;

    // A start word clears the parse and latches the radix.
    if (start_q) begin
      accumulator_next = '0;
      negative_next    = 1'b0;
      cnt_work         = '0;
      phase_next       = PH_LEAD;
      if (base_q == tuc_pkg::BASE_AUTO ||
          (base_q >= tuc_pkg::BASE_MIN && base_q <= tuc_pkg::BASE_MAX)) begin
        active_base_next = base_q;
      end else begin
        active_base_next = tuc_pkg::BASE_DEC;
      end
    end

    unique case (phase_next)
      PH_LEAD: begin
        if (cls.blank) begin
          count_inc = 1'b1;
        end else if (cls.sign) begin
          negative_next = cls.minus;
          count_inc     = 1'b1;
          phase_next    = PH_PREFIX;
        end else begin
          do_prefix = 1'b1;
        end
      end
      PH_PREFIX: do_prefix = 1'b1;
      PH_X16: begin
        if (cls.is_x) begin
          count_inc  = 1'b1;
          phase_next = PH_DIGITS;
        end else begin
          do_digit = 1'b1;
        end
      end
      PH_XAUTO: begin
        if (cls.is_x) begin
          active_base_next = tuc_pkg::BASE_HEX;
          count_inc        = 1'b1;
          phase_next       = PH_DIGITS;
        end else begin
          active_base_next = tuc_pkg::BASE_OCT;
          do_digit         = 1'b1;
        end
      end
      PH_DIGITS: do_digit = 1'b1;
      PH_IDLE, PH_DONE: ;
      default: ;
    endcase

    // Radix prefix: a leading 0 under hex or auto waits for an x.
    if (do_prefix) begin
      if (active_base_next == tuc_pkg::BASE_HEX && cls.zero) begin
        count_inc  = 1'b1;
        phase_next = PH_X16;
      end else if (active_base_next == tuc_pkg::BASE_AUTO && cls.zero) begin
        count_inc  = 1'b1;
        phase_next = PH_XAUTO;
      end else begin
        if (active_base_next == tuc_pkg::BASE_AUTO) begin
          active_base_next = tuc_pkg::BASE_DEC;
        end
        do_digit = 1'b1;
      end
    end

    // Digit: accumulate, or stop and emit the result.
    if (do_digit) begin
      if (cls.nul || !cls.is_digit || cls.digit >= active_base_next) begin
        emit            = 1'b1;
        phase_next      = PH_DONE;
        value_next      = negative_next ? (tuc_pkg::VALUE_BITS'(0) - accumulator_next)
                                        : accumulator_next;
        end_offset_next = cnt_work;
      end else begin
        accumulator_next = accumulator_next * tuc_pkg::VALUE_BITS'(active_base_next)
                         + tuc_pkg::VALUE_BITS'(cls.digit);
        count_inc        = 1'b1;
        phase_next       = PH_DIGITS;
      end
    end

    // Saturating count of consumed characters.
    consumed_count_next = cnt_work;
    if (count_inc && cnt_work != '1) begin
      consumed_count_next = cnt_work + tuc_pkg::OFFSET_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full        <= 1'b0;
      out_valid      <= 1'b0;
      phase          <= PH_IDLE;
      accumulator    <= '0;
      negative       <= 1'b0;
      active_base    <= tuc_pkg::BASE_DEC;
      consumed_count <= '0;
    end else begin
      // Input register: load on accept, drop once the step has used it.
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
        char_q  <= char_code;
        base_q  <= base_request;
        start_q <= start_req;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        out_valid <= in_full && emit;
        if (in_full) begin
          phase          <= phase_next;
          accumulator    <= accumulator_next;
          negative       <= negative_next;
          active_base    <= active_base_next;
          consumed_count <= consumed_count_next;
          if (emit) begin
            value      <= value_next;
            end_offset <= end_offset_next;
          end
        end
      end
    end
  end

  // A new result only comes from the step that ends a string.
  a_result_ends_parse : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> phase == PH_DONE)
    else $error("result appeared without the parse ending");

  // Without a start word the parser never leaves idle.
  a_idle_holds : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE && !(in_full && advance && start_q)) |=> phase == PH_IDLE)
    else $error("parser left idle without a start");

  // The working radix is auto-pending or a legal radix.
  a_base_legal : assert property (@(posedge clk) disable iff (rst)
    active_base == tuc_pkg::BASE_AUTO ||
    (active_base >= tuc_pkg::BASE_MIN && active_base <= tuc_pkg::BASE_MAX))
    else $error("active radix out of range");

  // Input stalls only while a character waits behind a blocked result.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_full && out_valid && out_stall))
    else $error("input stalled without cause");

endmodule
